/* sv/bdopr_pkg.sv */
`timescale 1ns / 1ps
package bdopr_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVRD,
    ST_EVCHK,
    ST_STORE,
    ST_POPRD,
    ST_OUT
  } state_e;

  localparam int unsigned RegIdxW     = 1;
  localparam logic [RegIdxW-1:0] RegMaxTime = 1'b0;
  localparam logic [RegIdxW-1:0] RegMaxMem  = 1'b1;
  localparam logic [39:0] DefaultBudget = 40'd524288000;
  localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;
  localparam int unsigned InW  = 96;
  localparam int unsigned OutW = 200;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, start duration divide
    logic div_step;  // one quotient bit
    logic rd_oldest; // read oldest entry
    logic retire;    // subtract oldest, advance read pointer
    logic store;     // write entry, add totals
    logic pop_out;   // build pop result
    logic clear;     // empty ring
    logic plain_out; // result without entry fields
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic evict;     // ring nonempty and a limit holds
  } sts_t;

endpackage

/* sv/bdopr_ctrl.sv */
`timescale 1ns / 1ps
module bdopr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_kind_i,
  input  logic              out_taken_i,
  input  logic              empty_i,
  input  bdopr_pkg::sts_t   sts_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output bdopr_pkg::ctl_t   ctl_o
);
  import bdopr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (kind_e'(in_kind_i))
            KIND_PUSH: begin
              ctl_o.load = 1'b1;
              state_d    = ST_DIV;
            end
            KIND_POP: begin
              if (empty_i) begin
                ctl_o.plain_out = 1'b1;
                state_d = ST_OUT;
              end else begin
                ctl_o.rd_oldest = 1'b1;
                state_d = ST_POPRD;
              end
            end
            KIND_CLEAR: begin
              ctl_o.clear = 1'b1;
              state_d = ST_OUT;
            end
            default: begin
              ctl_o.plain_out = 1'b1;
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_DIV: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          ctl_o.rd_oldest = 1'b1;
          state_d = ST_EVRD;
        end
      end
      ST_EVRD: state_d = ST_EVCHK;
      ST_EVCHK: begin
        if (sts_i.evict) begin
          ctl_o.retire = 1'b1;
          ctl_o.rd_oldest = 1'b1;
          state_d = ST_EVRD;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        ctl_o.store = 1'b1;
        state_d = ST_OUT;
      end
      ST_POPRD: begin
        ctl_o.pop_out = 1'b1;
        ctl_o.retire  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_taken_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* sv/bdopr_dpath.sv */
`timescale 1ns / 1ps
module bdopr_dpath #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [bdopr_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [39:0]          cfg_data_i,
  input  logic [bdopr_pkg::InW-1:0] in_data_i,
  input  bdopr_pkg::ctl_t      ctl_i,
  output bdopr_pkg::sts_t      sts_o,
  output logic                 empty_o,
  output logic [bdopr_pkg::OutW-1:0] out_data_o
);
  import bdopr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  logic [31:0] max_time_q;
  logic [39:0] max_mem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_time_q <= '0;
      max_mem_q  <= DefaultBudget;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxTime: max_time_q <= cfg_data_i[31:0];
        RegMaxMem:  max_mem_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memories: handle, attr {video, den, num, bytes}, duration
  logic [31:0] hmem [DEPTH];
  logic [56:0] amem [DEPTH];
  logic [25:0] dmem [DEPTH];
  logic [31:0] rd_h_q;
  logic [56:0] rd_a_q;
  logic [25:0] rd_d_q;

  logic [AW-1:0] wp_q, rp_q;
  logic [AW-1:0] rp_nx, wp_nx;
  logic [39:0]   tms_q, tby_q;
  logic          vid_q;
  logic [15:0]   num_q, den_q;
  logic [23:0]   by_q;
  logic [31:0]   hd_q;

  // restoring divide of num*1000 (26 bits) by den
  logic [25:0] quo_q;
  logic [16:0] rem_q;
  logic [4:0]  cnt_q;
  logic [16:0] rem_sh;
  logic [25:0] dur;

  assign rem_sh = {rem_q[15:0], quo_q[25]};
  assign dur = (vid_q && den_q != '0) ? quo_q : '0;
  assign sts_o.div_done = (cnt_q == 5'd0);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      vid_q <= in_data_i[2];
      num_q <= in_data_i[18:3];
      den_q <= in_data_i[34:19];
      by_q  <= in_data_i[58:35];
      hd_q  <= in_data_i[90:59];
      quo_q <= 26'(in_data_i[18:3]) * 26'd1000;
      rem_q <= '0;
      cnt_q <= 5'd26;
    end else if (ctl_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[24:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[24:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.store) begin
      hmem[wp_q] <= hd_q;
      amem[wp_q] <= {vid_q, den_q, num_q, by_q};
      dmem[wp_q] <= dur;
    end
    if (ctl_i.rd_oldest) begin
      rd_h_q <= hmem[ctl_i.retire ? rp_nx : rp_q];
      rd_a_q <= amem[ctl_i.retire ? rp_nx : rp_q];
      rd_d_q <= dmem[ctl_i.retire ? rp_nx : rp_q];
    end
  end

  assign rp_nx = (rp_q == LastSlot) ? '0 : rp_q + AW'(1);
  assign wp_nx = (wp_q == LastSlot) ? '0 : wp_q + AW'(1);
  assign empty_o = (wp_q == rp_q);

  logic [39:0] budget;
  logic [40:0] ms_sum, by_sum;
  assign budget = (max_mem_q != '0) ? max_mem_q : DefaultBudget;
  assign ms_sum = {1'b0, tms_q} + 41'(dur);
  assign by_sum = {1'b0, tby_q} + 41'(by_q);
  assign sts_o.evict = !empty_o &&
    (wp_nx == rp_q ||
     (ms_sum > 41'(max_time_q) && tms_q != '0) ||
     (by_sum > {1'b0, budget} && tby_q != '0));

  logic [9:0] drops_q;
  logic [39:0] ms_sub, by_sub;
  assign ms_sub = (tms_q >= 40'(rd_d_q)) ? tms_q - 40'(rd_d_q) : '0;
  assign by_sub = (tby_q >= 40'(rd_a_q[23:0])) ? tby_q - 40'(rd_a_q[23:0]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      tms_q <= '0;
      tby_q <= '0;
      drops_q <= '0;
    end else begin
      if (ctl_i.load) drops_q <= '0;
      if (ctl_i.retire) begin
        rp_q  <= rp_nx;
        tms_q <= ms_sub;
        tby_q <= by_sub;
        if (!ctl_i.pop_out) drops_q <= drops_q + 10'd1;
      end
      if (ctl_i.store) begin
        wp_q  <= wp_nx;
        tms_q <= ms_sum[40] ? Max40 : ms_sum[39:0];
        tby_q <= by_sum[40] ? Max40 : by_sum[39:0];
      end
      if (ctl_i.clear) begin
        rp_q  <= wp_q;
        tms_q <= '0;
        tby_q <= '0;
      end
    end
  end

  // result fields other than totals and count
  logic        ok_q;
  logic [31:0] oh_q;
  logic [23:0] ob_q;
  logic        ov_q;
  logic [15:0] on_q, od_q;
  logic [9:0]  odr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pop_out) begin
      ok_q <= 1'b1;
      oh_q <= rd_h_q;
      ob_q <= rd_a_q[23:0];
      on_q <= rd_a_q[39:24];
      od_q <= rd_a_q[55:40];
      ov_q <= rd_a_q[56];
      odr_q <= '0;
    end else if (ctl_i.store || ctl_i.clear || ctl_i.plain_out) begin
      ok_q <= ctl_i.store || ctl_i.clear;
      oh_q <= '0;
      ob_q <= '0;
      on_q <= '0;
      od_q <= '0;
      ov_q <= 1'b0;
      odr_q <= ctl_i.store ? drops_q : '0;
    end
  end

  logic [AW-1:0] cnt;
  logic [9:0]    cnt10;
  assign cnt = (wp_q >= rp_q) ? wp_q - rp_q : AW'(DEPTH - 32'(rp_q) + 32'(wp_q));
  assign cnt10 = 10'(cnt);

  assign out_data_o = {6'd0, cnt10, tby_q, tms_q, odr_q, od_q, on_q, ov_q, ob_q, oh_q, ok_q};
endmodule

/* sv/budgeted_drop_oldest_packet_ring_unit.sv */
`timescale 1ns / 1ps
// Drop-oldest packet-descriptor ring with time and byte budgets. One request at
// a time: a push runs a 26-step restoring divide for the video duration, then
// walks evictions, each a memory read and then a check, then stores. Each
// result is held while the sink stalls. At most DEPTH-1 entries are held.
// max_memory of 0 means 500 MB. The user must write config only while idle;
// the block itself does not enforce it.
module budgeted_drop_oldest_packet_ring_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [39:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[1:0], is_video[2], tb_num[18:3], tb_den[34:19], pkt_bytes[58:35],
  // packet_handle[90:59], zero pad
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ok[0], out_handle[32:1], out_bytes[56:33], out_is_video[57],
  // out_tb_num[73:58], out_tb_den[89:74], dropped[99:90], held_ms[139:100],
  // held_bytes[179:140], entry_count[189:180], zero pad
  output logic [199:0] m_axis_tdata
);
  import bdopr_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic empty;

  bdopr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tdata[1:0]),
    .out_taken_i (m_axis_tready),
    .empty_i     (empty),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .ctl_o       (ctl)
  );

  bdopr_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .empty_o    (empty),
    .out_data_o (m_axis_tdata)
  );
endmodule

/* sv/bdopr_checker.sv */
`timescale 1ns / 1ps
module bdopr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [95:0]  s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata
);
  import bdopr_pkg::*;

  // one request in flight: no accept while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");
  // result fields stay while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // clear result shows empty ring
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == KIND_CLEAR |=> ##1
    (m_axis_tdata[189:100] == '0 && m_axis_tdata[0])) else $error("clear not empty");
  // after a result is taken the unit is ready again
  a_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready) else $error("no return to idle");
endmodule

bind budgeted_drop_oldest_packet_ring_unit bdopr_checker u_bdopr_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
  import bdopr_pkg::*;

  localparam int unsigned RING = 1024;
  localparam longint unsigned LIMIT = 4000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [39:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // kind, is_video, tb_num, tb_den, pkt_bytes, packet_handle, zero pad
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // ok, out_handle, out_bytes, out_is_video, out_tb_num, out_tb_den, dropped,
  // held_ms, held_bytes, entry_count, zero pad
  logic [199:0] m_axis_tdata;

  budgeted_drop_oldest_packet_ring_unit uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Ring predictor and queue of pending responses.
  class ring_scoreboard;
    logic [31:0]  max_time;
    logic [39:0]  max_mem;
    logic [31:0]  hnd [RING];
    logic [56:0]  attr [RING];
    logic [25:0]  dur [RING];
    int unsigned  wp, rp;
    logic [39:0]  tot_ms, tot_bytes;
    logic [199:0] pending [$];
    int           errors;
    int           checked;

    function new();
      max_time = '0;
      max_mem = DefaultBudget;
      wp = 0;
      rp = 0;
      tot_ms = '0;
      tot_bytes = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic idx, logic [39:0] v);
      if (idx == RegMaxTime) max_time = v[31:0];
      else max_mem = v;
    endfunction

    function void retire();
      logic [39:0] b;
      b = {16'd0, attr[rp][23:0]};
      tot_ms = (tot_ms >= dur[rp]) ? tot_ms - dur[rp] : '0;
      tot_bytes = (tot_bytes >= b) ? tot_bytes - b : '0;
      rp = (rp + 1) % RING;
    endfunction

    function logic [39:0] add40(logic [39:0] a, logic [39:0] b);
      logic [40:0] s;
      s = a + b;
      return s[40] ? Max40 : s[39:0];
    endfunction

    function void note_request(logic [95:0] d);
      kind_e          k;
      logic [199:0]   r;
      logic [39:0]    dv, budget;
      logic [9:0]     drops;
      k = kind_e'(d[1:0]);
      r = '0;
      if (k == KIND_PUSH) begin
        dv = (d[2] && d[34:19] != 0) ? (40'(d[18:3]) * 1000) / d[34:19] : '0;
        budget = (max_mem != 0) ? max_mem : DefaultBudget;
        drops = '0;
        while (wp != rp && (((wp + 1) % RING) == rp ||
               (41'(tot_ms) + dv > 41'(max_time) && tot_ms != 0) ||
               (41'(tot_bytes) + d[58:35] > 41'(budget) && tot_bytes != 0))) begin
          retire();
          drops++;
        end
        hnd[wp] = d[90:59];
        attr[wp] = {d[2], d[34:19], d[18:3], d[58:35]};
        dur[wp] = dv[25:0];
        wp = (wp + 1) % RING;
        tot_ms = add40(tot_ms, dv);
        tot_bytes = add40(tot_bytes, {16'd0, d[58:35]});
        r[0] = 1'b1;
        r[99:90] = drops;
      end else if (k == KIND_POP) begin
        if (wp != rp) begin
          r[0] = 1'b1;
          r[32:1] = hnd[rp];
          r[56:33] = attr[rp][23:0];
          r[57] = attr[rp][56];
          r[73:58] = attr[rp][39:24];
          r[89:74] = attr[rp][55:40];
          retire();
        end
      end else if (k == KIND_CLEAR) begin
        rp = wp;
        tot_ms = '0;
        tot_bytes = '0;
        r[0] = 1'b1;
      end
      r[139:100] = tot_ms;
      r[179:140] = tot_bytes;
      r[189:180] = 10'((wp + RING - rp) % RING);
      pending.push_back(r);
    endfunction

    function int unsigned held();
      return (wp + RING - rp) % RING;
    endfunction

    task report(string what, logic [199:0] got, logic [199:0] want);
      errors++;
      if (errors <= 30) $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task check_response(logic [199:0] got);
      logic [199:0] w;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected response", got, '0);
        return;
      end
      w = pending.pop_front();
      if (got[0] !== w[0]) report("ok", got, w);
      if (got[32:1] !== w[32:1]) report("out_handle", got, w);
      if (got[56:33] !== w[56:33]) report("out_bytes", got, w);
      if (got[57] !== w[57]) report("out_is_video", got, w);
      if (got[73:58] !== w[73:58]) report("out_tb_num", got, w);
      if (got[89:74] !== w[89:74]) report("out_tb_den", got, w);
      if (got[99:90] !== w[99:90]) report("dropped", got, w);
      if (got[139:100] !== w[139:100]) report("held_ms", got, w);
      if (got[179:140] !== w[179:140]) report("held_bytes", got, w);
      if (got[189:180] !== w[189:180]) report("entry_count", got, w);
    endtask
  endclass

  ring_scoreboard sb = new();
  longint unsigned cycles = 0;
  bit   calm = 1'b0;       // no idling on either side
  int   hold_off = 0;      // sink stall length requested by stimulus
  int   pushes = 0, pops = 0, clears = 0, drops_seen = 0;

  // Sink: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tdata[99:90] != 0) drops_seen <= drops_seen + 1;
      sb.check_response(m_axis_tdata);
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  function automatic logic [95:0] make_req(kind_e k, logic v, logic [15:0] n,
                                           logic [15:0] dn, logic [23:0] b,
                                           logic [31:0] h);
    return {5'd0, h, b, dn, n, v, k};
  endfunction

  // The unit leaves idle on every accept, so the trailing wait with valid low
  // costs no throughput.
  task send(logic [95:0] d);
    if (!calm) begin
      while ($urandom_range(99) < 23) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(d);
    case (kind_e'(d[1:0]))
      KIND_PUSH: pushes++;
      KIND_POP: pops++;
      KIND_CLEAR: clears++;
      default: ;
    endcase
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Idle-only register write.
  task write_reg(logic idx, logic [39:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Random push, mostly small packets to keep the byte budget interesting.
  function automatic logic [95:0] rand_push();
    logic [23:0] b;
    logic [15:0] n, dn;
    b = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(4000));
    n = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(100));
    dn = ($urandom_range(9) == 0) ? 16'd0 :
         (($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60)));
    return make_req(KIND_PUSH, 1'($urandom), n, dn, b, $urandom);
  endfunction

  function automatic logic [95:0] rand_req();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 65) return rand_push();
    if (p < 93) return make_req(KIND_POP, 1'($urandom), 16'($urandom), 16'($urandom),
                                24'($urandom), $urandom);
    if (p < 97) return make_req(KIND_CLEAR, 1'($urandom), 16'($urandom),
                                16'($urandom), 24'($urandom), $urandom);
    return make_req(KIND_NONE, 1'($urandom), 16'($urandom), 16'($urandom),
                    24'($urandom), $urandom);
  endfunction

  initial begin
    int phase;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, extremes, zero denominator, unused kind, clear.
    write_reg(RegMaxTime, 40'hFFFF_FFFF);
    send(make_req(KIND_POP, 1'b0, '0, '0, '0, '0));
    send(make_req(KIND_PUSH, 1'b1, 16'hFFFF, 16'd1, 24'hFF_FFFF, 32'hFFFF_FFFF));
    send(make_req(KIND_PUSH, 1'b1, 16'hFFFF, 16'hFFFF, 24'd0, 32'h0));
    send(make_req(KIND_PUSH, 1'b1, 16'd7, 16'd0, 24'd1, 32'h1234_5678));
    send(make_req(KIND_PUSH, 1'b0, 16'd5, 16'd3, 24'd100, 32'hA5A5_A5A5));
    send(make_req(KIND_NONE, 1'b1, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF));
    repeat (5) send(make_req(KIND_POP, 1'b0, '0, '0, '0, '0));
    send(make_req(KIND_PUSH, 1'b1, 16'd1, 16'd3, 24'd9, 32'd77));
    send(make_req(KIND_CLEAR, 1'b0, '0, '0, '0, '0));
    send(make_req(KIND_POP, 1'b0, '0, '0, '0, '0));
    // Time budget: small limit forces evictions by duration.
    write_reg(RegMaxTime, 40'd1500);
    repeat (4) send(make_req(KIND_PUSH, 1'b1, 16'd1, 16'd1, 24'd10, $urandom));
    // Byte budget of one byte; zero budget selects the default.
    write_reg(RegMaxMem, 40'd1);
    repeat (3) send(make_req(KIND_PUSH, 1'b0, '0, '0, 24'd5, $urandom));
    write_reg(RegMaxMem, 40'd0);
    send(make_req(KIND_PUSH, 1'b0, '0, '0, 24'hFF_FFFF, $urandom));

    // Random phases across budget settings.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(RegMaxTime, 40'hFFFF_FFFF); write_reg(RegMaxMem, Max40); end
        1: begin write_reg(RegMaxTime, 40'd20000); write_reg(RegMaxMem, 40'd30000); end
        2: begin write_reg(RegMaxTime, 40'd0); write_reg(RegMaxMem, 40'd0); end
        3: begin write_reg(RegMaxTime, 40'($urandom)); write_reg(RegMaxMem, 40'd8000); end
        4: begin write_reg(RegMaxTime, 40'd500000); write_reg(RegMaxMem, 40'd600000); end
        default: begin write_reg(RegMaxTime, 40'hFFFF_FFFF); write_reg(RegMaxMem, Max40); end
      endcase
      calm = (phase == 1);
      if (phase == 2) hold_off = 400; // sink stalls long, source keeps offering
      repeat (55) send(rand_req());
      if (phase == 3) drain();       // source pauses until all results are in
    end

    // Fill the ring to the slot limit, then drop on fullness.
    write_reg(RegMaxTime, 40'hFFFF_FFFF);
    write_reg(RegMaxMem, Max40);
    send(make_req(KIND_CLEAR, 1'b0, '0, '0, '0, '0));
    while (sb.held() < RING - 1) send(make_req(KIND_PUSH, 1'b0, '0, '0, 24'd1, $urandom));
    repeat (20) send(rand_push());
    repeat (60) send(rand_req());

    drain();
    $display("covered %0d pushes, %0d pops, %0d clears; %0d results with evictions",
             pushes, pops, clears, drops_seen);
    $display("%0d results checked over several budget settings", sb.checked);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bdopr_pkg.sv
sv/bdopr_ctrl.sv
sv/bdopr_dpath.sv
sv/budgeted_drop_oldest_packet_ring_unit.sv
sv/bdopr_checker.sv
verif/tb.sv
